// ----- src/apogee_detect_airbrake_schedule_assert.svh -----
// Assertion macros for the apogee detector checker.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef APOGEE_DETECT_AIRBRAKE_SCHEDULE_ASSERT_SVH
`define APOGEE_DETECT_AIRBRAKE_SCHEDULE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define APDS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("apds assertion failed");

// antecedent implies consequent in the next cycle
`define APDS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("apds assertion failed");

`endif

// ----- src/apds_pkg.sv -----
// Shared constants, types and codes for the apogee detector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package apds_pkg;

    localparam int ALT_W     = 25;
    localparam int DIFF_W    = ALT_W + 1;
    localparam int TICK_W    = 16;
    localparam int TIME_W    = 24;
    localparam int VEL_W     = 24;
    localparam int POS_W     = 8;
    localparam int LIMIT_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam int WINDOW_LEN = 10;
    localparam int SLOT_W     = $clog2(WINDOW_LEN);
    localparam int SUM_W      = VEL_W + $clog2(WINDOW_LEN);

    localparam int SCALE      = 1000;
    localparam int PROD_W     = DIFF_W + $clog2(SCALE);
    localparam int DIV_W      = 2 * ((PROD_W + 1) / 2);
    localparam int VEL_ITERS  = DIV_W / 2;
    localparam int SUM_ITERS  = (SUM_W + 1) / 2;
    localparam int SUM_SHIFT  = DIV_W - 2 * SUM_ITERS;
    localparam int ITER_W     = $clog2(VEL_ITERS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VEL_W-1:0]   VEL_MAX   = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [LIMIT_W-1:0] COUNT_MAX = {LIMIT_W{1'b1}};

    localparam logic [TIME_W-1:0] T_WAIT_END  = TIME_W'(500);
    localparam logic [TIME_W-1:0] T_HALF_END  = TIME_W'(4500);
    localparam logic [TIME_W-1:0] T_TQ_END    = TIME_W'(6500);
    localparam logic [TIME_W-1:0] T_Q_END     = TIME_W'(8500);
    localparam logic [TIME_W-1:0] T_HALF2_END = TIME_W'(12500);

    localparam logic [LIMIT_W-1:0] RST_LIMIT      = LIMIT_W'(30);
    localparam logic [TIME_W-1:0]  RST_ABORT_TIME = TIME_W'(28500);
    localparam logic [POS_W-1:0]   RST_POS_RETR   = POS_W'(0);
    localparam logic [POS_W-1:0]   RST_POS_QTR    = POS_W'(45);
    localparam logic [POS_W-1:0]   RST_POS_HALF   = POS_W'(90);
    localparam logic [POS_W-1:0]   RST_POS_TQ     = POS_W'(135);

    typedef enum logic [2:0] {
        BP_WAIT,
        BP_HALF,
        BP_TQ,
        BP_Q,
        BP_HALF2,
        BP_RETRACTED
    } t_brake_phase;

    typedef enum logic [1:0] {
        NP_COAST,
        NP_DROGUE,
        NP_ABORT
    } t_next_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE,
        CFG_ABORT_TIME,
        CFG_POS_RETR,
        CFG_POS_QTR,
        CFG_POS_HALF,
        CFG_POS_TQ
    } t_cfg_index;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL,
        BK_VSTART,
        BK_VDIV,
        BK_SUM,
        BK_ASTART,
        BK_ADIV,
        BK_OUT
    } t_back_state;

    typedef struct packed {
        logic [LIMIT_W-1:0] debounce_limit;
        logic [TIME_W-1:0]  abort_time_ms;
        logic [POS_W-1:0]   pos_retracted;
        logic [POS_W-1:0]   pos_quarter;
        logic [POS_W-1:0]   pos_half;
        logic [POS_W-1:0]   pos_three_quarter;
    } t_cfg;

    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic [TICK_W-1:0] tick;
        logic [POS_W-1:0]  servo;
        logic              abort;
    } t_job;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [TICK_W-1:0] divisor;
        logic [ITER_W-1:0] iters;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic [POS_W-1:0] servo;
        logic [VEL_W-1:0] avg;
        logic             apogee;
        t_next_phase      next;
    } t_result;

endpackage

`default_nettype wire

// ----- src/apds_front.sv -----
// Front end: takes telemetry items, tracks altitude and brake schedule.
// Depends on apds_pkg; feeds the job queue.
`timescale 1ns / 1ps
`default_nettype none

module apds_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic signed [apds_pkg::ALT_W-1:0]   i_altitude_cm,
    input  logic [apds_pkg::TICK_W-1:0]         i_tick_ms,
    input  logic [apds_pkg::TIME_W-1:0]         i_coast_time_ms,
    input  apds_pkg::t_cfg                      i_cfg,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output apds_pkg::t_job                      o_job
);

    logic signed [apds_pkg::ALT_W-1:0] r_prev_alt;
    apds_pkg::t_brake_phase            r_phase;
    apds_pkg::t_brake_phase            n_phase;
    logic [apds_pkg::POS_W-1:0]        servo;

    always_comb begin
        n_phase = r_phase;
        servo   = i_cfg.pos_retracted;
        case (r_phase)
            apds_pkg::BP_WAIT: begin
                servo = i_cfg.pos_retracted;
                if (i_coast_time_ms >= apds_pkg::T_WAIT_END) n_phase = apds_pkg::BP_HALF;
            end
            apds_pkg::BP_HALF: begin
                servo = i_cfg.pos_half;
                if (i_coast_time_ms >= apds_pkg::T_HALF_END) n_phase = apds_pkg::BP_TQ;
            end
            apds_pkg::BP_TQ: begin
                servo = i_cfg.pos_three_quarter;
                if (i_coast_time_ms >= apds_pkg::T_TQ_END) n_phase = apds_pkg::BP_Q;
            end
            apds_pkg::BP_Q: begin
                servo = i_cfg.pos_quarter;
                if (i_coast_time_ms >= apds_pkg::T_Q_END) n_phase = apds_pkg::BP_HALF2;
            end
            apds_pkg::BP_HALF2: begin
                servo = i_cfg.pos_half;
                if (i_coast_time_ms >= apds_pkg::T_HALF2_END) begin
                    n_phase = apds_pkg::BP_RETRACTED;
                end
            end
            default: begin
                servo = i_cfg.pos_retracted;
            end
        endcase
    end

    always_comb begin
        o_q_push    = i_push && !i_q_full;
        o_job.diff  = apds_pkg::DIFF_W'(i_altitude_cm) - apds_pkg::DIFF_W'(r_prev_alt);
        o_job.tick  = i_tick_ms;
        o_job.servo = servo;
        o_job.abort = i_coast_time_ms > i_cfg.abort_time_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_alt <= '0;
            r_phase    <= apds_pkg::BP_WAIT;
        end else if (o_q_push) begin
            r_prev_alt <= i_altitude_cm;
            r_phase    <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ----- src/apds_fifo.sv -----
// Short job queue between front and back end.
// Depends on apds_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module apds_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  apds_pkg::t_job i_job,
    input  logic           i_pop,
    output apds_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);

    apds_pkg::t_job              r_mem [apds_pkg::QUEUE_DEPTH];
    logic [apds_pkg::QPTR_W-1:0] r_wr;
    logic [apds_pkg::QPTR_W-1:0] r_rd;
    logic [apds_pkg::QCNT_W-1:0] r_cnt;
    logic                        do_push;
    logic                        do_pop;

    always_comb begin
        o_full  = r_cnt == apds_pkg::QCNT_W'(apds_pkg::QUEUE_DEPTH);
        o_empty = r_cnt == '0;
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_job   = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == apds_pkg::QPTR_W'(apds_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == apds_pkg::QPTR_W'(apds_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- src/apds_div.sv -----
// Shared unsigned restoring divider, two quotient bits per cycle.
// Depends on apds_pkg; used by the back end for velocity and mean.
`timescale 1ns / 1ps
`default_nettype none

module apds_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  apds_pkg::t_div_req i_req,
    output apds_pkg::t_div_rsp o_rsp
);

    logic [apds_pkg::DIV_W-1:0]  r_q;
    logic [apds_pkg::TICK_W-1:0] r_rem;
    logic [apds_pkg::TICK_W-1:0] r_d;
    logic [apds_pkg::ITER_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [apds_pkg::DIV_W-1:0]  n_q;
    logic [apds_pkg::TICK_W-1:0] n_rem;

    always_comb begin
        logic [apds_pkg::TICK_W:0] trial;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_q[apds_pkg::DIV_W-1]};
            if (trial >= {1'b0, r_d}) begin
                n_rem = apds_pkg::TICK_W'(trial - {1'b0, r_d});
                n_q   = {n_q[apds_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[apds_pkg::TICK_W-1:0];
                n_q   = {n_q[apds_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_d   <= i_req.divisor;
            r_cnt <= i_req.iters;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == apds_pkg::ITER_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

`default_nettype wire

// ----- src/apds_back.sv -----
// Back end: velocity, window mean, debounce and result register.
// Depends on apds_pkg and apds_div; drains the job queue.
`timescale 1ns / 1ps
`default_nettype none

module apds_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  apds_pkg::t_job               i_job,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    input  logic [apds_pkg::LIMIT_W-1:0] i_debounce_limit,
    input  logic                         i_pop,
    output logic                         o_empty,
    output apds_pkg::t_result            o_result
);

    apds_pkg::t_back_state r_state;
    apds_pkg::t_back_state n_state;

    apds_pkg::t_job                     r_job;
    logic signed [apds_pkg::PROD_W-1:0] r_prod;
    logic signed [apds_pkg::VEL_W-1:0]  r_ring [apds_pkg::WINDOW_LEN];
    logic [apds_pkg::SLOT_W-1:0]        r_slot;
    logic [apds_pkg::SLOT_W-1:0]        r_idx;
    logic signed [apds_pkg::SUM_W-1:0]  r_sum;
    logic signed [apds_pkg::VEL_W-1:0]  r_avg;
    logic [apds_pkg::LIMIT_W-1:0]       r_count;
    logic                               r_out_valid;
    apds_pkg::t_result                  r_out;

    apds_pkg::t_div_req div_req;
    apds_pkg::t_div_rsp div_rsp;
    logic               div_start;
    logic               out_free;

    logic [apds_pkg::PROD_W-1:0]       prod_mag;
    logic [apds_pkg::SUM_W-1:0]        sum_mag;
    logic [apds_pkg::VEL_W-1:0]        vel_mag;
    logic signed [apds_pkg::VEL_W-1:0] vel;
    logic [apds_pkg::VEL_W-1:0]        avg_mag;
    logic signed [apds_pkg::VEL_W-1:0] avg;
    logic                              apogee;

    apds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        case (r_state)
            apds_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = apds_pkg::BK_MUL;
                end
            end
            apds_pkg::BK_MUL: begin
                n_state = apds_pkg::BK_VSTART;
            end
            apds_pkg::BK_VSTART: begin
                div_start = 1'b1;
                n_state   = apds_pkg::BK_VDIV;
            end
            apds_pkg::BK_VDIV: begin
                if (div_rsp.done) n_state = apds_pkg::BK_SUM;
            end
            apds_pkg::BK_SUM: begin
                if (r_idx == apds_pkg::SLOT_W'(apds_pkg::WINDOW_LEN - 1)) begin
                    n_state = apds_pkg::BK_ASTART;
                end
            end
            apds_pkg::BK_ASTART: begin
                div_start = 1'b1;
                n_state   = apds_pkg::BK_ADIV;
            end
            apds_pkg::BK_ADIV: begin
                if (div_rsp.done) n_state = apds_pkg::BK_OUT;
            end
            apds_pkg::BK_OUT: begin
                if (out_free) n_state = apds_pkg::BK_IDLE;
            end
            default: begin
                n_state = apds_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= apds_pkg::BK_IDLE;
        else          r_state <= n_state;
    end

    // magnitudes go through the divider; sign is put back afterwards
    always_comb begin
        out_free = !r_out_valid || i_pop;
        prod_mag = r_prod[apds_pkg::PROD_W-1] ? apds_pkg::PROD_W'(-r_prod) :
                                                 apds_pkg::PROD_W'(r_prod);
        sum_mag  = r_sum[apds_pkg::SUM_W-1] ? apds_pkg::SUM_W'(-r_sum) :
                                               apds_pkg::SUM_W'(r_sum);

        div_req.start = div_start;
        if (r_state == apds_pkg::BK_VSTART) begin
            div_req.dividend = apds_pkg::DIV_W'(prod_mag);
            div_req.divisor  = r_job.tick;
            div_req.iters    = apds_pkg::ITER_W'(apds_pkg::VEL_ITERS);
        end else begin
            div_req.dividend = apds_pkg::DIV_W'(sum_mag) << apds_pkg::SUM_SHIFT;
            div_req.divisor  = apds_pkg::TICK_W'(apds_pkg::WINDOW_LEN);
            div_req.iters    = apds_pkg::ITER_W'(apds_pkg::SUM_ITERS);
        end

        // zero tick gives an all-ones quotient, which saturates as required
        vel_mag = (div_rsp.quot > apds_pkg::DIV_W'(apds_pkg::VEL_MAX)) ?
                  apds_pkg::VEL_MAX : div_rsp.quot[apds_pkg::VEL_W-1:0];
        if (r_prod == '0)                      vel = '0;
        else if (r_prod[apds_pkg::PROD_W-1])   vel = -$signed(vel_mag);
        else                                   vel = $signed(vel_mag);

        avg_mag = div_rsp.quot[apds_pkg::VEL_W-1:0];
        avg     = r_sum[apds_pkg::SUM_W-1] ? -$signed(avg_mag) : $signed(avg_mag);

        apogee  = r_count > i_debounce_limit;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == apds_pkg::BK_IDLE && !i_q_empty) r_job <= i_job;
        if (r_state == apds_pkg::BK_MUL) begin
            r_prod <= apds_pkg::PROD_W'($signed(r_job.diff)) *
                      apds_pkg::PROD_W'(apds_pkg::SCALE);
        end
        if (r_state == apds_pkg::BK_VDIV && div_rsp.done) begin
            r_sum <= '0;
        end else if (r_state == apds_pkg::BK_SUM) begin
            r_sum <= r_sum + apds_pkg::SUM_W'(r_ring[r_idx]);
        end
        if (r_state == apds_pkg::BK_ADIV && div_rsp.done) r_avg <= avg;
        if (r_state == apds_pkg::BK_OUT && out_free) begin
            r_out.servo  <= r_job.servo;
            r_out.avg    <= r_avg;
            r_out.apogee <= apogee;
            if (apogee)           r_out.next <= apds_pkg::NP_DROGUE;
            else if (r_job.abort) r_out.next <= apds_pkg::NP_ABORT;
            else                  r_out.next <= apds_pkg::NP_COAST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < apds_pkg::WINDOW_LEN; i++) r_ring[i] <= '0;
            r_slot      <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == apds_pkg::BK_VDIV && div_rsp.done) begin
                r_ring[r_slot] <= vel;
                r_slot <= (r_slot == apds_pkg::SLOT_W'(apds_pkg::WINDOW_LEN - 1)) ?
                          '0 : r_slot + 1'b1;
                r_idx  <= '0;
            end else if (r_state == apds_pkg::BK_SUM) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == apds_pkg::BK_ADIV && div_rsp.done) begin
                if (avg[apds_pkg::VEL_W-1] || avg == '0) begin
                    if (r_count != apds_pkg::COUNT_MAX) r_count <= r_count + 1'b1;
                end else begin
                    r_count <= '0;
                end
            end
            if (r_state == apds_pkg::BK_OUT && out_free) r_out_valid <= 1'b1;
            else if (i_pop)                             r_out_valid <= 1'b0;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- src/apogee_detect_airbrake_schedule.sv -----
// Top level of the apogee detector and airbrake schedule.
// Depends on apds_pkg, apds_front, apds_fifo, apds_back (with apds_div).
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | i_push / o_full      | altitude_cm, tick_ms, coast_time_ms
//  result   | o_empty / i_pop      | servo_position, average_velocity,
//           |                      | apogee_seen, next_phase
//  config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
// An item passes from acceptance to result through the shared divider
// (18 steps for velocity, 14 for the mean, two bits a step) and the
// ten-entry window sum. One item is worked at a time; the queue holds two more.
// Synchronous active-low reset; no clearing pass, the window resets at once.
// A result left unpopped stalls the back end only after it finishes the next item.
`timescale 1ns / 1ps
`default_nettype none

module apogee_detect_airbrake_schedule (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic signed [apds_pkg::ALT_W-1:0]    i_altitude_cm,
    input  logic [apds_pkg::TICK_W-1:0]          i_tick_ms,
    input  logic [apds_pkg::TIME_W-1:0]          i_coast_time_ms,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic [apds_pkg::POS_W-1:0]           o_servo_position,
    output logic signed [apds_pkg::VEL_W-1:0]    o_average_velocity,
    output logic                                 o_apogee_seen,
    output logic [1:0]                           o_next_phase,
    input  logic                                 i_cfg_we,
    input  logic [apds_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [apds_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    apds_pkg::t_cfg    r_cfg;
    apds_pkg::t_job    front_job;
    apds_pkg::t_job    q_job;
    apds_pkg::t_result result;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_limit    <= apds_pkg::RST_LIMIT;
            r_cfg.abort_time_ms     <= apds_pkg::RST_ABORT_TIME;
            r_cfg.pos_retracted     <= apds_pkg::RST_POS_RETR;
            r_cfg.pos_quarter       <= apds_pkg::RST_POS_QTR;
            r_cfg.pos_half          <= apds_pkg::RST_POS_HALF;
            r_cfg.pos_three_quarter <= apds_pkg::RST_POS_TQ;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                apds_pkg::CFG_DEBOUNCE:   r_cfg.debounce_limit <= i_cfg_data[apds_pkg::LIMIT_W-1:0];
                apds_pkg::CFG_ABORT_TIME: r_cfg.abort_time_ms  <= i_cfg_data[apds_pkg::TIME_W-1:0];
                apds_pkg::CFG_POS_RETR:   r_cfg.pos_retracted  <= i_cfg_data[apds_pkg::POS_W-1:0];
                apds_pkg::CFG_POS_QTR:    r_cfg.pos_quarter    <= i_cfg_data[apds_pkg::POS_W-1:0];
                apds_pkg::CFG_POS_HALF:   r_cfg.pos_half       <= i_cfg_data[apds_pkg::POS_W-1:0];
                apds_pkg::CFG_POS_TQ: begin
                    r_cfg.pos_three_quarter <= i_cfg_data[apds_pkg::POS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    apds_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_altitude_cm   (i_altitude_cm),
        .i_tick_ms       (i_tick_ms),
        .i_coast_time_ms (i_coast_time_ms),
        .i_cfg           (r_cfg),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_job           (front_job)
    );

    apds_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    apds_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (q_job),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .i_debounce_limit (r_cfg.debounce_limit),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_result         (result)
    );

    assign o_full             = q_full;
    assign o_servo_position   = result.servo;
    assign o_average_velocity = $signed(result.avg);
    assign o_apogee_seen      = result.apogee;
    assign o_next_phase       = result.next;

endmodule

`default_nettype wire

// ----- src/apds_checker.sv -----
// Port-level checks for the apogee detector, bound to the top level.
// Depends on apds_pkg and apogee_detect_airbrake_schedule_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "apogee_detect_airbrake_schedule_assert.svh"

module apds_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_empty,
    input logic                              i_pop,
    input logic [apds_pkg::POS_W-1:0]        o_servo_position,
    input logic signed [apds_pkg::VEL_W-1:0] o_average_velocity,
    input logic                              o_apogee_seen,
    input logic [1:0]                        o_next_phase
);

    // apogee always wins the next-state choice
    `APDS_ASSERT_IMP(a_apogee_drogue, !o_empty && o_apogee_seen, o_next_phase == apds_pkg::NP_DROGUE)

    `APDS_ASSERT_IMP(a_drogue_needs_apogee, !o_empty && !o_apogee_seen, o_next_phase != apds_pkg::NP_DROGUE)

    // the mean is bounded by the saturated velocity, never the most negative code
    `APDS_ASSERT_IMP(a_avg_range, !o_empty, o_average_velocity != {1'b1, {(apds_pkg::VEL_W-1){1'b0}}})

    `APDS_ASSERT_NXT(a_result_held, !o_empty && !i_pop, !o_empty && $stable(o_average_velocity) && $stable(o_servo_position))

endmodule

bind apogee_detect_airbrake_schedule apds_checker u_apds_checker (.*);

`default_nettype wire
